/* sv/rsf_pkg.sv */
// Shared types and constants of the varispeed resampler with fades.
// Used by the shared multiplier, the fade divider and the top level.
`default_nettype none

package rsf_pkg;

  // Sample and phase formats.
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = 16;
  localparam int PHASE_W      = FRAC_BITS + 3;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_MIN  = PHASE_W'(1) << (FRAC_BITS - 2);
  localparam logic [PHASE_W-1:0] STEP_MAX  = PHASE_W'(4) << FRAC_BITS;

  // Gain formats: fade gains are unsigned Q1.16, clip gain is Q2.14.
  localparam int GAIN_FB    = 16;
  localparam int GAIN_W     = GAIN_FB + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FB;
  localparam int CLIP_GAIN_W = 16;
  localparam int CLIP_SHIFT  = 14;

  // Configuration widths.
  localparam int FADE_W   = 24;
  localparam int CLIP_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Outputs per input item.
  localparam int MAX_OUT = 4;
  localparam int ITER_W  = $clog2(MAX_OUT + 1);

  // Shared multiplier operand and result widths.
  localparam int MA_W   = SAMPLE_WIDTH + 1;
  localparam int MB_W   = (FRAC_BITS > GAIN_W) ? FRAC_BITS : GAIN_W;
  localparam int PROD_W = MA_W + MB_W + 1;
  localparam int RES_W  = SAMPLE_WIDTH + 5;

  // Divider widths: numerator below denominator, quotient of GAIN_FB bits.
  localparam int DIV_W     = FADE_W;
  localparam int DIV_CNT_W = $clog2(GAIN_FB);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE     = 3'd5;

  // Right shift applied after a multiply.
  typedef enum logic [1:0] {
    SH_FRAC,
    SH_GAIN,
    SH_CLIP
  } shift_e;

  // Request to the shared multiplier: res = (a * b) >>> shift + add.
  typedef struct packed {
    logic                           valid;
    logic signed [MA_W-1:0]         a;
    logic [MB_W-1:0]                b;
    shift_e                         sh;
    logic signed [SAMPLE_WIDTH-1:0] add;
  } mul_req_t;

  // Request to the fade divider: quot = (num << GAIN_FB) / den, num < den.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

/* sv/rsf_mul.sv */
// Shared multiply, shift and add unit with a registered result.
// Depends on rsf_pkg for the request type and widths.
`default_nettype none

module rsf_mul import rsf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_req_t                req_i,
  output logic signed [RES_W-1:0] res_o
);

  logic signed [MB_W:0]      b_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  shifted;
  logic signed [RES_W-1:0]   res_d;
  logic signed [RES_W-1:0]   res_q;

  // Signed product, floor shift and addend.
  always_comb begin
    b_s  = $signed({1'b0, req_i.b});
    prod = req_i.a * b_s;
    case (req_i.sh)
      SH_FRAC: shifted = prod >>> FRAC_BITS;
      SH_GAIN: shifted = prod >>> GAIN_FB;
      SH_CLIP: shifted = prod >>> CLIP_SHIFT;
      default: shifted = prod >>> CLIP_SHIFT;
    endcase
    res_d = $signed(shifted[RES_W-1:0]) + RES_W'(req_i.add);
  end

  // The result holds until the next request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (req_i.valid) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* sv/rsf_div.sv */
// Restoring divider for the fade gains, one quotient bit per cycle.
// Depends on rsf_pkg for the request type and widths.
`default_nettype none

module rsf_div import rsf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic [GAIN_FB-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     den_q;
  logic [GAIN_FB-1:0]   quot_q;
  logic [DIV_W:0]       rem_sh;
  logic                 fits;
  logic [DIV_W:0]       rem_nx;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    fits   = rem_sh >= {1'b0, den_q};
    rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    rem_d  = rem_nx[DIV_W-1:0];
  end

  // Iteration control.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(GAIN_FB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[GAIN_FB-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* sv/varispeed_resampler_with_fades.sv */
// Top level of the varispeed resampler: sequencer, state and output register.
// Depends on rsf_pkg, rsf_mul and rsf_div.
`default_nettype none

// Stereo linear-interpolation resampler with linear fade-in, fade-out and
// clip gain. Each accepted source frame yields zero to four output frames;
// the first frame after reset only primes the interpolator and leaves
// in_stall_o low. Items are worked one at a time: in_stall_o is high from the
// cycle after a request is taken until the sequencer is idle again, which is
// after its last output has been placed in the output register. An item's
// time grows with each output, with each fade gain that has to be divided
// (fade-in while the position is below the fade-in length, fade-out within
// the fade-out length of the clip end) and with each output that falls past
// the clip end. An output also waits while the output register still holds
// an earlier request that is stalled. This time is set by the single shared
// multiplier, which handles the interpolation and the three gain stages of
// both channels one after the other, and by the bit-serial fade divider. The
// output register lets the sequencer go on while a result waits.
// Configuration writes are always taken and should only be made while the
// block is idle.
module varispeed_resampler_with_fades import rsf_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  // Source frames.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_right_i,
  // Output frames.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_o,
  output logic                           last_of_run_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_GIN    = 4'd2;
  localparam logic [3:0] S_GIN_W  = 4'd3;
  localparam logic [3:0] S_GOUT   = 4'd4;
  localparam logic [3:0] S_GOUT_W = 4'd5;
  localparam logic [3:0] S_IL     = 4'd6;
  localparam logic [3:0] S_GIL    = 4'd7;
  localparam logic [3:0] S_GOL    = 4'd8;
  localparam logic [3:0] S_CGL    = 4'd9;
  localparam logic [3:0] S_IR     = 4'd10;
  localparam logic [3:0] S_GIR    = 4'd11;
  localparam logic [3:0] S_GOR    = 4'd12;
  localparam logic [3:0] S_CGR    = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  // Clamp a multiplier result to the sample range.
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[SAMPLE_WIDTH-1:0];
  endfunction

  // Configuration registers.
  logic [PHASE_W-1:0]     step_ratio_q;
  logic [FADE_W-1:0]      fade_in_q;
  logic [FADE_W-1:0]      fade_out_q;
  logic [CLIP_W-1:0]      clip_len_q;
  logic [CLIP_GAIN_W-1:0] clip_gain_q;
  logic                   mono_q;

  // Sequencer and stream state.
  logic [3:0]                     state_q, state_d;
  logic                           primed_q, primed_d;
  logic [PHASE_W-1:0]             phase_q, phase_d;
  logic [CLIP_W-1:0]              pos_q, pos_d;
  logic [ITER_W-1:0]              iter_q, iter_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_l_q, prev_l_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_r_q, prev_r_d;
  logic                           out_valid_q, out_valid_d;

  // Working payload.
  logic signed [SAMPLE_WIDTH-1:0] cur_l_q, cur_l_d;
  logic signed [SAMPLE_WIDTH-1:0] cur_r_q, cur_r_d;
  logic [GAIN_W-1:0]              gi_q, gi_d;
  logic [GAIN_W-1:0]              go_q, go_d;
  logic signed [SAMPLE_WIDTH-1:0] res_l_q, res_l_d;
  logic signed [SAMPLE_WIDTH-1:0] out_l_q, out_l_d;
  logic signed [SAMPLE_WIDTH-1:0] out_r_q, out_r_d;
  logic                           out_last_q, out_last_d;

  // Datapath helpers.
  logic [PHASE_W-1:0]         step_c;
  logic [PHASE_W-1:0]         phase_next;
  logic                       phase_ge_one;
  logic [CLIP_W-1:0]          rem_c;
  logic                       fade_in_on;
  logic                       fade_out_on;
  logic                       out_free;
  logic signed [SAMPLE_WIDTH-1:0] in_r_c;
  logic signed [MA_W-1:0]     mul_acc;
  mul_req_t                   mul_req;
  logic signed [RES_W-1:0]    mul_res;
  div_req_t                   div_req;
  logic                       div_done;
  logic [GAIN_FB-1:0]         div_quot;

  rsf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .res_o  (mul_res)
  );

  rsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q <= PHASE_W'(65536);
      fade_in_q    <= '0;
      fade_out_q   <= '0;
      clip_len_q   <= '1;
      clip_gain_q  <= CLIP_GAIN_W'(16384);
      mono_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_RATIO:      step_ratio_q <= cfg_data_i[PHASE_W-1:0];
        REG_FADE_IN_LENGTH:  fade_in_q    <= cfg_data_i[FADE_W-1:0];
        REG_FADE_OUT_LENGTH: fade_out_q   <= cfg_data_i[FADE_W-1:0];
        REG_CLIP_LENGTH:     clip_len_q   <= cfg_data_i[CLIP_W-1:0];
        REG_CLIP_GAIN:       clip_gain_q  <= cfg_data_i[CLIP_GAIN_W-1:0];
        REG_MONO_SOURCE:     mono_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Step clamp, phase and fade window decisions.
  always_comb begin
    if (step_ratio_q < STEP_MIN) begin
      step_c = STEP_MIN;
    end else if (step_ratio_q > STEP_MAX) begin
      step_c = STEP_MAX;
    end else begin
      step_c = step_ratio_q;
    end
    phase_next   = phase_q + step_c;
    phase_ge_one = phase_q >= PHASE_ONE;
    rem_c        = clip_len_q - pos_q;
    fade_in_on   = (fade_in_q != '0) && (pos_q < CLIP_W'(fade_in_q));
    fade_out_on  = (fade_out_q != '0) && (rem_c < CLIP_W'(fade_out_q));
    out_free     = !out_valid_q || !out_stall_i;
    in_r_c       = mono_q ? sample_left_i : sample_right_i;
    mul_acc      = MA_W'($signed(mul_res[SAMPLE_WIDTH-1:0]));
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    iter_d      = iter_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    out_valid_d = out_valid_q;
    cur_l_d     = cur_l_q;
    cur_r_d     = cur_r_q;
    gi_d        = gi_q;
    go_d        = go_q;
    res_l_d     = res_l_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_last_d  = out_last_q;

    mul_req       = '0;
    mul_req.a     = mul_acc;
    mul_req.sh    = SH_GAIN;
    div_req.start = 1'b0;
    div_req.num   = pos_q[DIV_W-1:0];
    div_req.den   = fade_in_q;

    // The output register empties when its request is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!primed_q) begin
            prev_l_d = sample_left_i;
            prev_r_d = in_r_c;
            primed_d = 1'b1;
            phase_d  = '0;
          end else begin
            cur_l_d = sample_left_i;
            cur_r_d = in_r_c;
            iter_d  = '0;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!phase_ge_one && (iter_q < ITER_W'(MAX_OUT))) begin
          if (pos_q < clip_len_q) begin
            state_d = S_GIN;
          end else begin
            // Past the clip end: the phase advances, nothing is emitted.
            phase_d = phase_next;
            iter_d  = iter_q + ITER_W'(1);
          end
        end else begin
          phase_d  = phase_ge_one ? (phase_q - PHASE_ONE) : phase_q;
          prev_l_d = cur_l_q;
          prev_r_d = cur_r_q;
          state_d  = S_IDLE;
        end
      end
      S_GIN: begin
        if (fade_in_on) begin
          div_req.start = 1'b1;
          state_d       = S_GIN_W;
        end else begin
          gi_d    = GAIN_ONE;
          state_d = S_GOUT;
        end
      end
      S_GIN_W: begin
        if (div_done) begin
          gi_d    = GAIN_W'(div_quot);
          state_d = S_GOUT;
        end
      end
      S_GOUT: begin
        div_req.num = rem_c[DIV_W-1:0];
        div_req.den = fade_out_q;
        if (fade_out_on) begin
          div_req.start = 1'b1;
          state_d       = S_GOUT_W;
        end else begin
          go_d    = GAIN_ONE;
          state_d = S_IL;
        end
      end
      S_GOUT_W: begin
        if (div_done) begin
          go_d    = GAIN_W'(div_quot);
          state_d = S_IL;
        end
      end
      S_IL: begin
        mul_req.valid = 1'b1;
        mul_req.a     = MA_W'(cur_l_q) - MA_W'(prev_l_q);
        mul_req.b     = MB_W'(phase_q[FRAC_BITS-1:0]);
        mul_req.sh    = SH_FRAC;
        mul_req.add   = prev_l_q;
        state_d       = S_GIL;
      end
      S_GIL: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(gi_q);
        state_d       = S_GOL;
      end
      S_GOL: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(go_q);
        state_d       = S_CGL;
      end
      S_CGL: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(clip_gain_q);
        mul_req.sh    = SH_CLIP;
        state_d       = S_IR;
      end
      S_IR: begin
        res_l_d       = sat(mul_res);
        mul_req.valid = 1'b1;
        mul_req.a     = MA_W'(cur_r_q) - MA_W'(prev_r_q);
        mul_req.b     = MB_W'(phase_q[FRAC_BITS-1:0]);
        mul_req.sh    = SH_FRAC;
        mul_req.add   = prev_r_q;
        state_d       = S_GIR;
      end
      S_GIR: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(gi_q);
        state_d       = S_GOR;
      end
      S_GOR: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(go_q);
        state_d       = S_CGR;
      end
      S_CGR: begin
        mul_req.valid = 1'b1;
        mul_req.b     = MB_W'(clip_gain_q);
        mul_req.sh    = SH_CLIP;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_l_d     = res_l_q;
          out_r_d     = sat(mul_res);
          // Last unless another output of this item will reach the clip.
          out_last_d  = !((phase_next < PHASE_ONE) &&
                          (iter_q != ITER_W'(MAX_OUT - 1)) &&
                          (rem_c != CLIP_W'(1)));
          pos_d       = pos_q + CLIP_W'(1);
          phase_d     = phase_next;
          iter_d      = iter_q + ITER_W'(1);
          state_d     = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      primed_q    <= 1'b0;
      phase_q     <= '0;
      pos_q       <= '0;
      iter_q      <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      iter_q      <= iter_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_l_q    <= cur_l_d;
    cur_r_q    <= cur_r_d;
    gi_q       <= gi_d;
    go_q       <= go_d;
    res_l_q    <= res_l_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign out_left_o    = out_l_q;
  assign out_right_o   = out_r_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

/* sv/rsf_checker.sv */
// Port-level checks of the varispeed resampler, bound to the top level.
// Depends on rsf_pkg for widths.
`default_nettype none

module rsf_checker import rsf_pkg::*; (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  input logic signed [SAMPLE_WIDTH-1:0] out_right_o,
  input logic                           last_of_run_o
);

  // A stalled output request stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_left_o) &&
      $stable(out_right_o) && $stable(last_of_run_o))
    else $error("stalled output request changed");

  // While an output that is not the last of its item waits, the item is
  // still being worked, so no new source frame can be taken.
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("source frame taken in the middle of a run");

  // A frame taken with an empty output register cannot show a result at once.
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("output appeared the cycle after a source frame");

endmodule

bind varispeed_resampler_with_fades rsf_checker u_rsf_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the varispeed resampler with fades.
// Predicts the interpolated, faded and gained output frames of every source frame and
// compares them with the outputs; depends on rsf_pkg and varispeed_resampler_with_fades.
`default_nettype none

module tb;
  import rsf_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int IDLE_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 436;

  localparam logic signed [SAMPLE_WIDTH-1:0] FULL_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] FULL_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // One output frame as the block presents it.
  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           run_end;
  } out_frame_t;

  // Register settings of the block.
  typedef struct {
    logic [PHASE_W-1:0]     step_ratio;
    logic [FADE_W-1:0]      fade_in_len;
    logic [FADE_W-1:0]      fade_out_len;
    logic [CLIP_W-1:0]      clip_len;
    logic [CLIP_GAIN_W-1:0] clip_gain;
    logic                   mono;
  } reg_set_t;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i     = '0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_left_i  = '0;
  logic signed [SAMPLE_WIDTH-1:0] sample_right_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_left_o;
  logic signed [SAMPLE_WIDTH-1:0] out_right_o;
  logic                           last_of_run_o;

  // Predicted state of the resampler, kept in step with accepted requests.
  reg_set_t                       regs = '{step_ratio: PHASE_ONE, fade_in_len: '0,
                                           fade_out_len: '0, clip_len: '1,
                                           clip_gain: CLIP_GAIN_W'(16384), mono: 1'b0};
  logic signed [SAMPLE_WIDTH-1:0] hold_left   = '0;
  logic signed [SAMPLE_WIDTH-1:0] hold_right  = '0;
  logic [PHASE_W-1:0]             read_phase  = '0;
  logic                           primed      = 1'b0;
  logic [CLIP_W-1:0]              frames_sent = '0;

  out_frame_t due_frames[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         gap_odds = 3;
  int         stall_odds = 4;
  int         stall_left = 0;

  varispeed_resampler_with_fades uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Clock with a period of 10 time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit in case the block stops responding.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d frames still due", cycle_count,
               due_frames.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output stalls come in random bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      stall_left  <= $urandom_range(1, 5);
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
             want);
  endtask

  // Compare every accepted output frame with the oldest predicted one.
  always @(posedge clk_i) begin : check_outputs
    out_frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_frames.size() == 0) begin
        report_mismatch("output frame with none due, left", out_left_o, 0);
      end else begin
        want = due_frames.pop_front();
        if (out_left_o !== want.left)
          report_mismatch("out_left", out_left_o, want.left);
        if (out_right_o !== want.right)
          report_mismatch("out_right", out_right_o, want.right);
        if (last_of_run_o !== want.run_end)
          report_mismatch("last_of_run", last_of_run_o, want.run_end);
      end
    end
  end

  // Gain chain: fade-in, fade-out, then clip gain, each a floored shift.
  function automatic longint apply_gain_chain(input longint s, input longint gi,
                                              input longint go);
    longint v;
    v = (s * gi) >>> GAIN_FB;
    v = (v * go) >>> GAIN_FB;
    v = (v * longint'(regs.clip_gain)) >>> CLIP_SHIFT;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(input longint v);
    if (v > longint'(FULL_POS))
      return FULL_POS;
    if (v < longint'(FULL_NEG))
      return FULL_NEG;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Work out the output frames that one source frame causes and queue them.
  task automatic resample_source_frame(input logic signed [SAMPLE_WIDTH-1:0] l,
                                       input logic signed [SAMPLE_WIDTH-1:0] r);
    longint     cur_l, cur_r, prev_l, prev_r, step, ph, il, ir, gi, go, pos, rem;
    longint     clip, fin, fout;
    int         iter;
    out_frame_t batch[$];
    out_frame_t f;
    cur_l  = l;
    cur_r  = regs.mono ? cur_l : longint'(r);
    prev_l = hold_left;
    prev_r = hold_right;
    clip   = regs.clip_len;
    fin    = regs.fade_in_len;
    fout   = regs.fade_out_len;
    iter   = 0;

    // An out-of-range step is clamped to a quarter up to four source frames.
    step = regs.step_ratio;
    if (step < longint'(STEP_MIN))
      step = STEP_MIN;
    if (step > longint'(STEP_MAX))
      step = STEP_MAX;

    // The first frame after reset only primes the interpolator.
    if (!primed) begin
      hold_left  = cur_l;
      hold_right = cur_r;
      primed     = 1'b1;
      read_phase = '0;
      return;
    end

    ph = read_phase;
    while (ph < longint'(PHASE_ONE) && iter < MAX_OUT) begin
      il = prev_l + (((cur_l - prev_l) * ph) >>> FRAC_BITS);
      ir = prev_r + (((cur_r - prev_r) * ph) >>> FRAC_BITS);
      iter++;
      // Frames at or past the clip end are dropped without moving the position.
      if (longint'(frames_sent) < clip) begin
        pos = frames_sent;
        gi  = GAIN_ONE;
        go  = GAIN_ONE;
        if (fin != 0 && pos < fin)
          gi = (pos << GAIN_FB) / fin;
        if (fout != 0) begin
          rem = clip - pos;
          if (rem < fout)
            go = (rem << GAIN_FB) / fout;
        end
        f.left    = clamp_sample(apply_gain_chain(il, gi, go));
        f.right   = clamp_sample(apply_gain_chain(ir, gi, go));
        f.run_end = 1'b0;
        batch.push_back(f);
        frames_sent = frames_sent + 1;
      end
      ph += step;
    end
    if (ph >= longint'(PHASE_ONE))
      ph -= longint'(PHASE_ONE);
    read_phase = ph[PHASE_W-1:0];

    if (batch.size() > 0)
      batch[batch.size() - 1].run_end = 1'b1;
    foreach (batch[i])
      due_frames.push_back(batch[i]);
    hold_left  = cur_l;
    hold_right = cur_r;
  endtask

  // Send one source frame, now and then after a random gap, and predict its outputs.
  task automatic send_frame(input logic signed [SAMPLE_WIDTH-1:0] l,
                            input logic signed [SAMPLE_WIDTH-1:0] r);
    int gap;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_left_i  <= l;
    sample_right_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    resample_source_frame(l, r);
  endtask

  // Wait until every due frame has come out and the block has had time to finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write request; valid stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_STEP_RATIO:      regs.step_ratio   = data[PHASE_W-1:0];
      REG_FADE_IN_LENGTH:  regs.fade_in_len  = data[FADE_W-1:0];
      REG_FADE_OUT_LENGTH: regs.fade_out_len = data[FADE_W-1:0];
      REG_CLIP_LENGTH:     regs.clip_len     = data[CLIP_W-1:0];
      REG_CLIP_GAIN:       regs.clip_gain    = data[CLIP_GAIN_W-1:0];
      REG_MONO_SOURCE:     regs.mono         = data[0];
      default: ;
    endcase
  endtask

  // Bring the block to idle, then write all six registers.
  task automatic program_regs(input reg_set_t s);
    wait_idle();
    write_reg(REG_STEP_RATIO, CFG_DATA_W'(s.step_ratio));
    write_reg(REG_FADE_IN_LENGTH, CFG_DATA_W'(s.fade_in_len));
    write_reg(REG_FADE_OUT_LENGTH, CFG_DATA_W'(s.fade_out_len));
    write_reg(REG_CLIP_LENGTH, CFG_DATA_W'(s.clip_len));
    write_reg(REG_CLIP_GAIN, CFG_DATA_W'(s.clip_gain));
    write_reg(REG_MONO_SOURCE, CFG_DATA_W'(s.mono));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return SAMPLE_WIDTH'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  // Reset register values: priming, unity step and gain, full-scale samples.
  task automatic test_priming_and_full_scale();
    send_frame(FULL_POS, FULL_NEG);
    send_frame(FULL_NEG, FULL_POS);
    send_frame('0, '0);
    send_frame(FULL_POS, FULL_POS);
    send_frame(-SAMPLE_WIDTH'(1), SAMPLE_WIDTH'(1));
  endtask

  // Fade-in ramp over a few frames at the slowest step, then the longest fade-in.
  task automatic test_fade_in();
    reg_set_t s;
    s = regs;
    s.fade_in_len = FADE_W'(frames_sent) + FADE_W'(4);
    s.step_ratio  = STEP_MIN;
    program_regs(s);
    send_frame(FULL_NEG, FULL_POS);
    send_frame(FULL_POS, FULL_NEG);
    s.fade_in_len = '1;
    program_regs(s);
    send_frame(SAMPLE_WIDTH'(12345), -SAMPLE_WIDTH'(54321));
  endtask

  // Steps outside the legal range are clamped; the top of the range too.
  task automatic test_step_limits();
    reg_set_t s;
    s = regs;
    s.fade_in_len = '0;
    s.step_ratio  = '0;
    program_regs(s);
    send_frame(FULL_POS, SAMPLE_WIDTH'(1000));
    send_frame(FULL_NEG, -SAMPLE_WIDTH'(1000));
    s.step_ratio = '1;
    program_regs(s);
    send_frame(SAMPLE_WIDTH'(777), FULL_POS);
    send_frame(FULL_NEG, '0);
    s.step_ratio = STEP_MAX;
    program_regs(s);
    send_frame(FULL_POS, FULL_NEG);
  endtask

  // Fade-out toward the clip end, frames past the end, and a zero clip length.
  task automatic test_fade_out_and_clip_end();
    reg_set_t s;
    s = regs;
    s.step_ratio   = PHASE_ONE;
    s.clip_len     = frames_sent + CLIP_W'(3);
    s.fade_out_len = FADE_W'(4);
    program_regs(s);
    repeat (5) send_frame(FULL_POS, FULL_NEG);
    s.clip_len     = frames_sent + CLIP_W'(2);
    s.fade_out_len = '1;
    program_regs(s);
    send_frame(FULL_NEG, FULL_POS);
    send_frame(FULL_POS, FULL_POS);
    s.clip_len = '0;
    program_regs(s);
    send_frame(FULL_NEG, FULL_NEG);
  endtask

  // Largest clip gain saturates; mono copies left to right; zero gain silences.
  task automatic test_gain_and_mono();
    reg_set_t s;
    s = regs;
    s.clip_len     = '1;
    s.fade_out_len = '0;
    s.clip_gain    = '1;
    s.mono         = 1'b1;
    program_regs(s);
    send_frame(FULL_POS, '0);
    send_frame(FULL_NEG, SAMPLE_WIDTH'(123));
    s.clip_gain = '0;
    program_regs(s);
    send_frame(FULL_POS, FULL_NEG);
  endtask

  // Random settings per phase, random frames within it; the last phase runs flat out.
  task automatic test_random_phases();
    reg_set_t s;
    int       items_left;
    int       n;
    items_left = RANDOM_ITEMS;
    while (items_left > 0) begin
      n = $urandom_range(15, 45);
      if (n >= items_left)
        n = items_left;
      items_left -= n;

      if ($urandom_range(0, 7) == 0)
        s.step_ratio = $urandom_range(0, 1) ? PHASE_W'($urandom_range(0, STEP_MIN - 1))
                                            : PHASE_W'($urandom_range(STEP_MAX + 1, (1 << PHASE_W) - 1));
      else
        s.step_ratio = PHASE_W'($urandom_range(STEP_MIN, STEP_MAX));
      case ($urandom_range(0, 2))
        0:       s.fade_in_len = '0;
        1:       s.fade_in_len = FADE_W'(frames_sent) + FADE_W'($urandom_range(1, 200));
        default: s.fade_in_len = FADE_W'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0:       s.fade_out_len = '0;
        1, 2:    s.fade_out_len = FADE_W'($urandom_range(1, 150));
        default: s.fade_out_len = FADE_W'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0:       s.clip_len = frames_sent + CLIP_W'($urandom_range(10, 120));
        1:       s.clip_len = '1;
        default: s.clip_len = CLIP_W'($urandom());
      endcase
      s.clip_gain = $urandom_range(0, 1) ? CLIP_GAIN_W'($urandom())
                                         : CLIP_GAIN_W'($urandom_range(12000, 20000));
      s.mono = 1'($urandom_range(0, 1));
      program_regs(s);

      // Idling varies per phase, including phases without any.
      if (items_left == 0) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 3) * 3;
        stall_odds = $urandom_range(0, 3) * 3;
      end
      repeat (n) send_frame(rand_sample(), rand_sample());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_priming_and_full_scale();
    test_fade_in();
    test_step_limits();
    test_fade_out_and_clip_end();
    test_gain_and_mono();
    test_random_phases();
    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
